### rtl/core/spcpi_pkg.sv
// package: sizes, payload structs, status codes and memory request structs
package spcpi_pkg;

  localparam int NUM_COLUMNS = 64;
  localparam int COL_SLOTS   = 16;

  localparam int COL_W   = $clog2(NUM_COLUMNS);
  localparam int ROW_W   = $clog2(NUM_COLUMNS);
  localparam int POS_W   = $clog2(COL_SLOTS + 1);
  localparam int ADDR_W  = $clog2(NUM_COLUMNS * COL_SLOTS);
  localparam int LIM_W   = $clog2(NUM_COLUMNS + 1);
  localparam int CFG_W   = 7;
  localparam int RNUM_W  = 8;
  localparam int TOTAL_W = 11;
  localparam int CMP_W   = (LIM_W > RNUM_W) ? LIM_W : RNUM_W;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_INACTIVE = 3'd2,
    ST_FULL     = 3'd3,
    ST_RANGE    = 3'd4,
    ST_CLEARED  = 3'd5
  } status_t;

  typedef struct packed {
    logic                     kind;
    logic [COL_W-1:0]         column;
    logic signed [RNUM_W-1:0] row_number;
    logic                     last_in_list;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [POS_W-1:0]   position;
    logic [POS_W-1:0]   column_length;
    logic [TOTAL_W-1:0] total_count;
    logic               list_done;
  } out_item_t;

  typedef struct packed {
    logic             rd;
    logic [COL_W-1:0] rd_col;
    logic             wr;
    logic [COL_W-1:0] wr_col;
    logic [POS_W-1:0] wr_len;
    logic             clear;
  } len_req_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ROW_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } store_req_t;

endpackage

### rtl/core/spcpi_ram.sv
// generic simple dual-port ram with registered read
module spcpi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/spcpi_len_table.sv
// column length table: ram plus per-column valid bits, all cleared at once by a clear request
module spcpi_len_table (
  input  logic                      clk,
  input  logic                      rst_n,
  input  spcpi_pkg::len_req_t       req,
  output logic [spcpi_pkg::POS_W-1:0] rdata
);

  logic [spcpi_pkg::NUM_COLUMNS-1:0] valid_r, valid_nxt;
  logic                              rd_vld_r, rd_vld_nxt;
  logic [spcpi_pkg::POS_W-1:0]       ram_q;

  spcpi_ram #(
    .WIDTH (spcpi_pkg::POS_W),
    .DEPTH (spcpi_pkg::NUM_COLUMNS)
  ) u_len_ram (
    .clk   (clk),
    .we    (req.wr),
    .waddr (req.wr_col),
    .wdata (req.wr_len),
    .re    (req.rd),
    .raddr (req.rd_col),
    .rdata (ram_q)
  );

  always_comb begin
    valid_nxt  = valid_r;
    rd_vld_nxt = rd_vld_r;
    if (req.clear) begin
      valid_nxt = '0;
    end else if (req.wr) begin
      valid_nxt[req.wr_col] = 1'b1;
    end
    if (req.rd) begin
      rd_vld_nxt = valid_r[req.rd_col];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  // a column never written since the last clear reads as empty
  assign rdata = rd_vld_r ? ram_q : '0;

endmodule

### rtl/core/spcpi_ctrl.sv
// sequencer: length lookup, column scan, shift-up and insert
module spcpi_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  spcpi_pkg::in_item_t           in_data,
  input  logic                          cfg_we,
  input  logic [spcpi_pkg::CFG_W-1:0]   cfg_wdata,
  output logic                          res_valid,
  input  logic                          res_take,
  output spcpi_pkg::out_item_t          res_data,
  output spcpi_pkg::len_req_t           len_req,
  input  logic [spcpi_pkg::POS_W-1:0]   len_rdata,
  output spcpi_pkg::store_req_t         st_req,
  input  logic [spcpi_pkg::ROW_W-1:0]   st_rdata
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LEN   = 6'b000010,
    S_SCAN  = 6'b000100,
    S_SHIFT = 6'b001000,
    S_INS   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t                          state_r, state_nxt;
  spcpi_pkg::in_item_t             item_r, item_nxt;
  spcpi_pkg::out_item_t            res_r, res_nxt;
  logic [spcpi_pkg::ADDR_W-1:0]    base_r, base_nxt;
  logic [spcpi_pkg::POS_W-1:0]     len_r, len_nxt;
  logic [spcpi_pkg::POS_W-1:0]     j_r, j_nxt;
  logic [spcpi_pkg::POS_W-1:0]     k_r, k_nxt;
  logic [spcpi_pkg::ROW_W-1:0]     newrow_r, newrow_nxt;
  logic [spcpi_pkg::TOTAL_W-1:0]   total_r, total_nxt;
  logic [spcpi_pkg::CFG_W-1:0]     cfg_r;

  logic [spcpi_pkg::CMP_W-1:0]     cfg_ext, ncol_ext, limit;
  logic [spcpi_pkg::CMP_W-1:0]     col_ext, rn_ext;
  logic                            rn_inactive;
  logic [spcpi_pkg::POS_W-1:0]     jn, kn, scan_pos;
  logic                            scan_end;

  always_comb begin
    cfg_ext  = spcpi_pkg::CMP_W'(cfg_r);
    ncol_ext = spcpi_pkg::CMP_W'(spcpi_pkg::NUM_COLUMNS);
    limit    = (cfg_ext > ncol_ext) ? ncol_ext : cfg_ext;
    col_ext  = spcpi_pkg::CMP_W'(in_data.column);
    rn_ext   = spcpi_pkg::CMP_W'($unsigned(item_r.row_number));
    rn_inactive = item_r.row_number[spcpi_pkg::RNUM_W-1] || (item_r.row_number == '0);
  end

  always_comb begin
    state_nxt  = state_r;
    item_nxt   = item_r;
    res_nxt    = res_r;
    base_nxt   = base_r;
    len_nxt    = len_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    newrow_nxt = newrow_r;
    total_nxt  = total_r;
    len_req    = '0;
    st_req     = '0;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    jn         = j_r + spcpi_pkg::POS_W'(1);
    kn         = k_r - spcpi_pkg::POS_W'(1);
    scan_end   = 1'b0;
    scan_pos   = j_r;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt = in_data;
          if (in_data.kind) begin
            len_req.clear = 1'b1;
            total_nxt     = '0;
            res_nxt       = '{spcpi_pkg::ST_CLEARED, '0, '0, '0, in_data.last_in_list};
            state_nxt     = S_DONE;
          end else if (col_ext >= limit) begin
            res_nxt   = '{spcpi_pkg::ST_RANGE, '0, '0, total_r, in_data.last_in_list};
            state_nxt = S_DONE;
          end else begin
            len_req.rd     = 1'b1;
            len_req.rd_col = in_data.column;
            base_nxt = spcpi_pkg::ADDR_W'(in_data.column)
                     * spcpi_pkg::ADDR_W'(spcpi_pkg::COL_SLOTS);
            state_nxt = S_LEN;
          end
        end
      end

      S_LEN: begin
        len_nxt    = len_rdata;
        j_nxt      = '0;
        newrow_nxt = spcpi_pkg::ROW_W'(rn_ext - spcpi_pkg::CMP_W'(1));
        if (rn_inactive) begin
          res_nxt   = '{spcpi_pkg::ST_INACTIVE, '0, len_rdata, total_r, item_r.last_in_list};
          state_nxt = S_DONE;
        end else if (rn_ext > limit) begin
          res_nxt   = '{spcpi_pkg::ST_RANGE, '0, len_rdata, total_r, item_r.last_in_list};
          state_nxt = S_DONE;
        end else if (len_rdata == '0) begin
          state_nxt = S_INS;
        end else begin
          st_req.re    = 1'b1;
          st_req.raddr = base_r;
          state_nxt    = S_SCAN;
        end
      end

      S_SCAN: begin
        if (newrow_r < st_rdata) begin
          scan_end = 1'b1;
          scan_pos = j_r;
        end else if (newrow_r == st_rdata) begin
          res_nxt   = '{spcpi_pkg::ST_PRESENT, j_r, len_r, total_r, item_r.last_in_list};
          state_nxt = S_DONE;
        end else if (jn < len_r) begin
          j_nxt        = jn;
          st_req.re    = 1'b1;
          st_req.raddr = base_r + spcpi_pkg::ADDR_W'(jn);
        end else begin
          scan_end = 1'b1;
          scan_pos = jn;
        end
        if (scan_end) begin
          j_nxt = scan_pos;
          if (len_r >= spcpi_pkg::POS_W'(spcpi_pkg::COL_SLOTS)) begin
            res_nxt   = '{spcpi_pkg::ST_FULL, scan_pos, len_r, total_r, item_r.last_in_list};
            state_nxt = S_DONE;
          end else if (len_r > scan_pos) begin
            // move the top entry first, one slot per cycle downward
            k_nxt        = len_r;
            st_req.re    = 1'b1;
            st_req.raddr = base_r + spcpi_pkg::ADDR_W'(len_r - spcpi_pkg::POS_W'(1));
            state_nxt    = S_SHIFT;
          end else begin
            state_nxt = S_INS;
          end
        end
      end

      S_SHIFT: begin
        st_req.we    = 1'b1;
        st_req.waddr = base_r + spcpi_pkg::ADDR_W'(k_r);
        st_req.wdata = st_rdata;
        k_nxt        = kn;
        if (kn > j_r) begin
          st_req.re    = 1'b1;
          st_req.raddr = base_r + spcpi_pkg::ADDR_W'(kn - spcpi_pkg::POS_W'(1));
        end else begin
          state_nxt = S_INS;
        end
      end

      S_INS: begin
        st_req.we      = 1'b1;
        st_req.waddr   = base_r + spcpi_pkg::ADDR_W'(j_r);
        st_req.wdata   = newrow_r;
        len_req.wr     = 1'b1;
        len_req.wr_col = item_r.column;
        len_req.wr_len = len_r + spcpi_pkg::POS_W'(1);
        total_nxt      = total_r + spcpi_pkg::TOTAL_W'(1);
        res_nxt = '{spcpi_pkg::ST_INSERTED, j_r, len_r + spcpi_pkg::POS_W'(1),
                    total_r + spcpi_pkg::TOTAL_W'(1), item_r.last_in_list};
        state_nxt = S_DONE;
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res_data = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      total_r <= '0;
      cfg_r   <= spcpi_pkg::CFG_RESET;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    res_r    <= res_nxt;
    base_r   <= base_nxt;
    len_r    <= len_nxt;
    j_r      <= j_nxt;
    k_r      <= k_nxt;
    newrow_r <= newrow_nxt;
  end

endmodule

### rtl/core/sparse_column_pattern_insert.sv
// top level: sparsity pattern builder with row store, length table and output register
//
// sorted-unique insert into compressed-column slot regions. each column owns
// COL_SLOTS consecutive slots of a single-port-write/single-port-read row
// store ram and keeps zero-based row indices there in ascending order. one
// item is worked on at a time; the next transfer is taken once the previous
// result has moved into the output register, so a result waiting on out_ready
// does not hold up the next item's work. from transfer to result ready for the
// output register: a clear or an out-of-range column goes straight to the
// result; an inactive or out-of-range row takes the length lookup first;
// otherwise the length lookup, a scan that reads s column entries, a shift-up
// of h entries and, when inserting, the insert write follow, with one row
// store access of each kind per cycle. s + h never exceeds the column length
// plus one. the column length table sits in a small ram with a valid flop per
// column, so a clear resets every column at once and no clearing pass runs
// after reset. the row store itself is never cleared; only slots below a
// column's length are ever read.
module sparse_column_pattern_insert (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  spcpi_pkg::in_item_t         in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output spcpi_pkg::out_item_t        out_data,
  input  logic                        cfg_we,
  input  logic [spcpi_pkg::CFG_W-1:0] cfg_wdata
);

  spcpi_pkg::len_req_t           len_req;
  spcpi_pkg::store_req_t         st_req;
  logic [spcpi_pkg::POS_W-1:0]   len_rdata;
  logic [spcpi_pkg::ROW_W-1:0]   st_rdata;

  logic                          res_valid;
  logic                          res_take;
  spcpi_pkg::out_item_t          res_data;

  // output register
  logic                          out_valid_r, out_valid_nxt;
  spcpi_pkg::out_item_t          out_data_r;

  // row store: one write and one read per cycle, read data registered and valid in the next cycle
  spcpi_ram #(
    .WIDTH (spcpi_pkg::ROW_W),
    .DEPTH (spcpi_pkg::NUM_COLUMNS * spcpi_pkg::COL_SLOTS)
  ) u_row_store (
    .clk   (clk),
    .we    (st_req.we),
    .waddr (st_req.waddr),
    .wdata (st_req.wdata),
    .re    (st_req.re),
    .raddr (st_req.raddr),
    .rdata (st_rdata)
  );

  spcpi_len_table u_len_table (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (len_req),
    .rdata (len_rdata)
  );

  spcpi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res_data  (res_data),
    .len_req   (len_req),
    .len_rdata (len_rdata),
    .st_req    (st_req),
    .st_rdata  (st_rdata)
  );

  // the sequencer hands over its result when the output register is free
  // or is being emptied by a transfer in this cycle
  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // one item in flight: no second transfer right after an accepted one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is still in work");

  // a clear result always reports an empty pattern
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == spcpi_pkg::ST_CLEARED |->
      out_data.total_count == '0 && out_data.column_length == '0)
    else $error("clear result with nonzero length or total");

  // column length never exceeds the slot region
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.column_length <= spcpi_pkg::POS_W'(spcpi_pkg::COL_SLOTS))
    else $error("column length beyond slot count");

  // an inserted or present row sits inside the column
  a_pos_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == spcpi_pkg::ST_INSERTED ||
                  out_data.status == spcpi_pkg::ST_PRESENT) |->
      out_data.position < out_data.column_length)
    else $error("reported position outside column");

  // a result is loaded only into a free or draining output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("output register overwritten while waiting");

endmodule
